/* hdl/psu_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Particle swarm update package
// Shared constants and types for the particle swarm update block.
// ----------------------------------------------------------------------------
package psu_pkg;

    localparam int unsigned MAX_PARTICLES_DEF = 64;

    localparam logic [1:0] FUNC_LOAD   = 2'd0;
    localparam logic [1:0] FUNC_REPORT = 2'd1;
    localparam logic [1:0] FUNC_UPDATE = 2'd2;

    localparam logic [2:0] REG_COUNT   = 3'd0;
    localparam logic [2:0] REG_INERTIA = 3'd1;
    localparam logic [2:0] REG_COGN    = 3'd2;
    localparam logic [2:0] REG_SOCIAL  = 3'd3;
    localparam logic [2:0] REG_FLOOR   = 3'd4;
    localparam logic [2:0] REG_CEIL    = 3'd5;

    localparam logic signed [31:0] FIT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [23:0] POS_MAX = 24'sh7F_FFFF;
    localparam logic signed [23:0] POS_MIN = -24'sh80_0000;

    // Memory word: position, velocity, pbest position, pbest fitness, latest fitness.
    typedef struct packed {
        logic signed [23:0] pos;
        logic signed [23:0] vel;
        logic signed [23:0] pb_pos;
        logic signed [31:0] pb_fit;
        logic signed [31:0] last_fit;
    } t_entry;

    localparam int unsigned ENTRY_W = $bits(t_entry);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_MUL,
        ST_SUM,
        ST_SAT,
        ST_WRITE,
        ST_OUT
    } t_state;

endpackage

/* hdl/psu_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module psu_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 64,
    parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/particle_swarm_update_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Particle swarm update, top level
// One-dimensional global-best particle swarm kept in one particle RAM.
// ----------------------------------------------------------------------------
// Each accepted transaction runs through read, multiply, sum, saturate,
// write-back and the output register before its result is offered.
// Transactions do not overlap: the next item is accepted only in the idle
// state after the six states of the single read-modify-write pass; a new
// item is taken while the result waits, and a result that is still held stalls
// the pass in its output state.
// Reset (synchronous, active low) restores the register defaults and the round
// best; the particle RAM is not cleared and holds garbage until loaded.
// ----------------------------------------------------------------------------
module particle_swarm_update_top #(
    parameter int unsigned MAX_PARTICLES = psu_pkg::MAX_PARTICLES_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // Configuration write port.
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_index,
    input  logic [23:0]  i_cfg_data,
    // Input stream. tdata from bit 0: func[1:0], particle_index[7:2],
    // start_position[31:8], fitness_value[63:32], rand_cognitive[80:64],
    // rand_social[97:81], zero fill to 104 bits.
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [103:0] s_axis_tdata,
    // Output stream. tdata from bit 0: out_index[5:0], new_position[29:6],
    // new_velocity[53:30], global_best_position[77:54],
    // global_best_fitness[109:78], global_best_index[115:110], zero fill to 120.
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [119:0] m_axis_tdata
);
    import psu_pkg::*;

    localparam int unsigned AW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;

    // Configuration registers.
    logic [6:0]         r_count;
    logic [15:0]        r_w, r_c1, r_c2;
    logic signed [23:0] r_floor, r_ceil;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 7'd20;
            r_w     <= 16'd1638;
            r_c1    <= 16'd4096;
            r_c2    <= 16'd4096;
            r_floor <= 24'sd0;
            r_ceil  <= 24'sd524288;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_COUNT:   r_count <= i_cfg_data[6:0];
                REG_INERTIA: r_w     <= i_cfg_data[15:0];
                REG_COGN:    r_c1    <= i_cfg_data[15:0];
                REG_SOCIAL:  r_c2    <= i_cfg_data[15:0];
                REG_FLOOR:   r_floor <= i_cfg_data;
                REG_CEIL:    r_ceil  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Captured transaction.
    t_state             r_state, n_state;
    logic [1:0]         r_func;
    logic [5:0]         r_idx;
    logic               r_valid;
    logic signed [23:0] r_start;
    logic signed [31:0] r_fit;
    logic [16:0]        r_rc, r_rs;

    // Round best.
    logic signed [31:0] r_gb_fit;
    logic signed [23:0] r_gb_pos;
    logic [5:0]         r_gb_idx;

    // Datapath registers.
    t_entry             r_ent;
    logic [32:0]        r_k1, r_k2;
    logic signed [24:0] r_d1, r_d2;
    logic signed [63:0] r_t0, r_t1, r_t2;
    logic signed [23:0] r_nv;

    // Output register.
    logic               r_ovalid;
    logic [119:0]       r_odata;

    t_entry             rd_ent, wr_ent;
    logic               mem_we;
    logic [AW-1:0]      ram_addr;

    assign ram_addr = AW'(r_idx);

    psu_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_PARTICLES)) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (ram_addr),
        .i_wdata (wr_ent),
        .i_raddr (ram_addr),
        .o_rdata (rd_ent)
    );

    wire in_fire = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE);

    // Personal best position as the update will see it, taken straight from the
    // RAM output so that the differences can be formed while the entry is latched.
    logic signed [23:0] rd_pb_pos;
    always_comb begin
        rd_pb_pos = (rd_ent.last_fit < rd_ent.pb_fit) ? rd_ent.pos : rd_ent.pb_pos;
    end

    // Personal best refresh, evaluated on the registered entry.
    t_entry             pb_ent;
    always_comb begin
        pb_ent = r_ent;
        if (r_ent.last_fit < r_ent.pb_fit) begin
            pb_ent.pb_fit = r_ent.last_fit;
            pb_ent.pb_pos = r_ent.pos;
        end
    end

    // Rounding and saturation of the Q.44 sum.
    logic signed [65:0] sum;
    logic signed [37:0] rnd;
    logic signed [23:0] nv_sat;
    logic signed [24:0] nx;
    logic signed [24:0] nx_lo;
    always_comb begin
        sum = 66'(r_t0) + 66'(r_t1) + 66'(r_t2) + 66'sd134217728;
        rnd = sum[65:28];
        if (rnd > 38'(POS_MAX)) begin
            nv_sat = POS_MAX;
        end else if (rnd < 38'(POS_MIN)) begin
            nv_sat = POS_MIN;
        end else begin
            nv_sat = rnd[23:0];
        end
        nx  = 25'(r_ent.pos) + 25'(r_nv);
        nx_lo = (nx < 25'(r_floor)) ? 25'(r_floor) : nx;
    end

    always_comb begin
        n_state = r_state;
        mem_we  = 1'b0;
        wr_ent  = r_ent;
        unique case (r_state)
            ST_IDLE:  if (in_fire) n_state = ST_READ;
            ST_READ:  n_state = ST_MUL;
            ST_MUL:   n_state = ST_SUM;
            ST_SUM:   n_state = ST_SAT;
            ST_SAT:   n_state = ST_WRITE;
            ST_WRITE: begin
                if (r_valid) begin
                    case (r_func)
                        FUNC_LOAD: begin
                            mem_we        = 1'b1;
                            wr_ent.pos    = r_start;
                            wr_ent.vel    = '0;
                            wr_ent.pb_pos = r_start;
                            wr_ent.pb_fit = FIT_MAX;
                        end
                        FUNC_REPORT: begin
                            mem_we          = 1'b1;
                            wr_ent.last_fit = r_fit;
                        end
                        FUNC_UPDATE: begin
                            mem_we     = 1'b1;
                            wr_ent     = pb_ent;
                            wr_ent.vel = r_nv;
                            wr_ent.pos = (nx_lo > 25'(r_ceil)) ? r_ceil : nx_lo[23:0];
                        end
                        default: ;
                    endcase
                end
                n_state = ST_OUT;
            end
            ST_OUT:   if (!r_ovalid || m_axis_tready) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
            r_gb_fit <= FIT_MAX;
            r_gb_pos <= '0;
            r_gb_idx <= '0;
        end else begin
            r_state <= n_state;
            // A new result takes the output register as the old one leaves.
            if (r_state == ST_OUT && (!r_ovalid || m_axis_tready)) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            if (r_state == ST_WRITE && r_valid && r_func == FUNC_REPORT
                && (r_idx == 6'd0 || r_fit < r_gb_fit)) begin
                r_gb_fit <= r_fit;
                r_gb_pos <= r_ent.pos;
                r_gb_idx <= r_idx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_func  <= s_axis_tdata[1:0];
            r_idx   <= s_axis_tdata[7:2];
            r_start <= s_axis_tdata[31:8];
            r_fit   <= s_axis_tdata[63:32];
            r_rc    <= s_axis_tdata[80:64];
            r_rs    <= s_axis_tdata[97:81];
            r_valid <= ({1'b0, s_axis_tdata[7:2]} < r_count)
                       && (32'(s_axis_tdata[7:2]) < MAX_PARTICLES);
        end
        if (r_state == ST_READ) begin
            r_k1  <= 33'(r_rc) * 33'(r_c1);
            r_k2  <= 33'(r_rs) * 33'(r_c2);
        end
        // The RAM output holds the entry during this state.
        if (r_state == ST_MUL) begin
            r_ent <= rd_ent;
            r_d1 <= 25'(rd_pb_pos) - 25'(rd_ent.pos);
            r_d2 <= 25'(r_gb_pos) - 25'(rd_ent.pos);
            r_t0 <= 64'($signed({1'b0, r_w}) * 41'(rd_ent.vel)) <<< 16;
        end
        if (r_state == ST_SUM) begin
            r_t1 <= 64'($signed({1'b0, r_k1}) * 59'(r_d1));
            r_t2 <= 64'($signed({1'b0, r_k2}) * 59'(r_d2));
        end
        if (r_state == ST_WRITE) begin
            r_ent <= wr_ent;
        end
        if (r_state == ST_OUT && (!r_ovalid || m_axis_tready)) begin
            r_odata <= {4'd0, r_gb_idx, r_gb_fit, r_gb_pos,
                        r_valid ? r_ent.vel : 24'd0,
                        r_valid ? r_ent.pos : 24'd0, r_idx};
        end
    end

    // Velocity saturation; registered in the state that follows the last products.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_SAT) begin
            r_nv <= nv_sat;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

endmodule

/* tb/particle_swarm_update_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Particle swarm update testbench
// Drives load, fitness-report, update and reserved transactions into the swarm block
// under changing register settings and random stalls on both streams. Every
// output transaction is compared field by field with a behavioral copy of the
// swarm kept in this bench.
// ----------------------------------------------------------------------------
module particle_swarm_update_top_tb;
    import psu_pkg::*;

    localparam logic [1:0] FUNC_RESERVED = 2'd3;
    localparam int         NPART         = 64;
    localparam int         STALL_LIMIT   = 3000;
    localparam int         LONG_HOLD     = 300;

    typedef struct {
        logic [5:0]         idx;
        logic signed [23:0] pos;
        logic signed [23:0] vel;
        logic signed [23:0] gbest_pos;
        logic signed [31:0] gbest_fit;
        logic [5:0]         gbest_idx;
    } swarm_result_t;

    typedef struct {
        logic [1:0]         func;
        logic [5:0]         idx;
        logic signed [23:0] start_pos;
        logic signed [31:0] fitness;
        logic [16:0]        r_cogn;
        logic [16:0]        r_soc;
        bit                 has_value;
        swarm_result_t      value;
    } stim_row_t;

    typedef struct {
        int            seq;
        swarm_result_t value;
    } fixed_check_t;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_cfg_we = 1'b0;
    logic [2:0]   i_cfg_index = '0;
    logic [23:0]  i_cfg_data = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [103:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [119:0] m_axis_tdata;

    particle_swarm_update_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #10 i_clk = ~i_clk;

    // Shadow copy of the swarm: registers, particle memory and round best.
    longint             sw_count, sw_inertia, sw_cogn, sw_social;
    logic signed [23:0] sw_floor, sw_ceil;
    logic signed [23:0] sw_pos [NPART];
    logic signed [23:0] sw_vel [NPART];
    logic signed [23:0] sw_pb_pos [NPART];
    logic signed [31:0] sw_pb_fit [NPART];
    logic signed [31:0] sw_last_fit [NPART];
    logic signed [31:0] sw_best_fit;
    logic signed [23:0] sw_best_pos;
    logic [5:0]         sw_best_idx;

    // Which particles have been loaded / have reported a fitness, so that the
    // stimulus never reads a memory entry that was never written.
    bit loaded [NPART];
    bit reported [NPART];

    swarm_result_t expected_results[$];
    fixed_check_t  fixed_checks[$];
    int            accepted_count = 0;
    int            result_count = 0;
    int            error_count = 0;
    int            idle_cycles = 0;
    int            update_count = 0;
    int            config_phases = 0;
    bit            hold_request = 1'b0;
    bit            quiet = 1'b0;

    // Velocity update in Q.44, rounded to Q8.16, saturated, then move and clamp.
    function automatic void swarm_update(int i, longint r_cogn, longint r_soc);
        longint x, v, pb, gb, acc, nv, nx;
        if (sw_last_fit[i] < sw_pb_fit[i]) begin
            sw_pb_fit[i] = sw_last_fit[i];
            sw_pb_pos[i] = sw_pos[i];
        end
        x   = sw_pos[i];
        v   = sw_vel[i];
        pb  = sw_pb_pos[i];
        gb  = sw_best_pos;
        acc = sw_inertia * v * 64'sd65536
            + (r_cogn * sw_cogn) * (pb - x)
            + (r_soc * sw_social) * (gb - x);
        nv  = (acc + (64'sd1 <<< 27)) >>> 28;
        if (nv > longint'(POS_MAX)) nv = POS_MAX;
        if (nv < longint'(POS_MIN)) nv = POS_MIN;
        nx = x + nv;
        if (nx < longint'(sw_floor)) nx = sw_floor;
        if (nx > longint'(sw_ceil)) nx = sw_ceil;
        sw_vel[i] = nv[23:0];
        sw_pos[i] = nx[23:0];
    endfunction

    function automatic swarm_result_t swarm_predict(logic [103:0] d);
        swarm_result_t r;
        logic [1:0]    f;
        int            i;
        f = d[1:0];
        i = d[7:2];
        r.idx = d[7:2];
        r.pos = '0;
        r.vel = '0;
        if (i < sw_count) begin
            case (f)
                FUNC_LOAD: begin
                    sw_pos[i]    = d[31:8];
                    sw_vel[i]    = '0;
                    sw_pb_pos[i] = d[31:8];
                    sw_pb_fit[i] = FIT_MAX;
                end
                FUNC_REPORT: begin
                    sw_last_fit[i] = d[63:32];
                    // Index zero restarts the round; others need strictly lower.
                    if (i == 0 || $signed(d[63:32]) < sw_best_fit) begin
                        sw_best_fit = d[63:32];
                        sw_best_pos = sw_pos[i];
                        sw_best_idx = i;
                    end
                end
                FUNC_UPDATE: begin
                    swarm_update(i, longint'(d[80:64]), longint'(d[97:81]));
                    update_count++;
                end
                default: ;
            endcase
            r.pos = sw_pos[i];
            r.vel = sw_vel[i];
        end
        r.gbest_pos = sw_best_pos;
        r.gbest_fit = sw_best_fit;
        r.gbest_idx = sw_best_idx;
        return r;
    endfunction

    // Input monitor: every accepted transaction feeds the predictor.
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            expected_results.push_back(swarm_predict(s_axis_tdata));
        end
    end

    task automatic compare_field(string name, longint exp_v, longint act_v);
        if (exp_v != act_v) begin
            $display("%0t: mismatch in %s of result %0d: expected %0d, actual %0d",
                     $time, name, result_count, exp_v, act_v);
            error_count++;
        end
    endtask

    task automatic compare_result(swarm_result_t e, logic [119:0] d);
        compare_field("out_index", e.idx, d[5:0]);
        compare_field("new_position", e.pos, $signed(d[29:6]));
        compare_field("new_velocity", e.vel, $signed(d[53:30]));
        compare_field("global_best_position", e.gbest_pos, $signed(d[77:54]));
        compare_field("global_best_fitness", e.gbest_fit, $signed(d[109:78]));
        compare_field("global_best_index", e.gbest_idx, d[115:110]);
    endtask

    // Output checker: in-order comparison against the oldest expectation, plus
    // the hand-written values of a few directed rows.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result transaction, data %h", $time, m_axis_tdata);
                error_count++;
            end else begin
                compare_result(expected_results.pop_front(), m_axis_tdata);
            end
            if (fixed_checks.size() != 0 && fixed_checks[0].seq == result_count) begin
                compare_result(fixed_checks.pop_front().value, m_axis_tdata);
            end
            result_count++;
        end
    end

    // Watchdog: ends the run when no transaction moves on either side for too long.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles > STALL_LIMIT) begin
                $display("%0t: timeout, %0d results still outstanding",
                         $time, expected_results.size());
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // Receiver: random back-pressure bursts, one long hold-off on request, and
    // none at all once the bench enters its quiet last phase.
    initial begin
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_request) begin
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                hold_request = 1'b0;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    task automatic send_item(logic [1:0] f, int idx, logic [23:0] sp, logic [31:0] fit,
                             logic [16:0] rc, logic [16:0] rs);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'd0, rs, rc, fit, sp, idx[5:0], f};
        do @(posedge i_clk); while (!s_axis_tready);
        accepted_count++;
        if (idx < sw_count) begin
            if (f == FUNC_LOAD) loaded[idx] = 1'b1;
            if (f == FUNC_REPORT) reported[idx] = 1'b1;
        end
    endtask

    // Stop sending and wait until the block has drained.
    task automatic drain;
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] index, logic [23:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        case (index)
            REG_COUNT:   sw_count   = value[6:0];
            REG_INERTIA: sw_inertia = value[15:0];
            REG_COGN:    sw_cogn    = value[15:0];
            REG_SOCIAL:  sw_social  = value[15:0];
            REG_FLOOR:   sw_floor   = value;
            REG_CEIL:    sw_ceil    = value;
            default: ;
        endcase
    endtask

    task automatic configure(int count, int w, int c1, int c2, int lo, int hi);
        drain();
        write_reg(REG_COUNT, count);
        write_reg(REG_INERTIA, w);
        write_reg(REG_COGN, c1);
        write_reg(REG_SOCIAL, c2);
        write_reg(REG_FLOOR, lo);
        write_reg(REG_CEIL, hi);
        config_phases++;
    endtask

    function automatic logic [16:0] rand_unit();
        if ($urandom_range(0, 7) == 0) return $urandom_range(0, 131071);
        return $urandom_range(0, 65536);
    endfunction

    function automatic logic [31:0] rand_fitness(logic [31:0] prev);
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return prev;  // ties must keep the first particle
            default: return $urandom_range(0, 1 << 20) - (1 << 19);
        endcase
    endfunction

    // Any item that would touch an entry never written becomes a load.
    task automatic send_legal(logic [1:0] f, int idx, logic [31:0] fit);
        logic [23:0] sp;
        sp = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(sw_ceil, sw_floor);
        if (idx < sw_count) begin
            if (!loaded[idx] || (f == FUNC_UPDATE && !reported[idx])) f = FUNC_LOAD;
        end
        send_item(f, idx, sp, fit, rand_unit(), rand_unit());
    endtask

    // One random phase: mostly full swarm iterations (report every particle
    // from index zero up, then update all), the rest scattered noise.
    task automatic random_phase(int n_items);
        int          sent;
        logic [31:0] fit;
        sent = 0;
        fit  = $urandom();
        while (sent < n_items) begin
            if ($urandom_range(0, 3) != 0) begin
                for (int i = 0; i < sw_count; i++) begin
                    fit = rand_fitness(fit);
                    send_legal(FUNC_REPORT, i, fit);
                end
                for (int i = 0; i < sw_count; i++) send_legal(FUNC_UPDATE, i, $urandom());
                sent += 2 * sw_count;
            end else begin
                for (int k = 0; k < 8; k++) begin
                    fit = rand_fitness(fit);
                    send_legal($urandom_range(0, 3), $urandom_range(0, 63), fit);
                end
                sent += 8;
            end
        end
    endtask

    stim_row_t directed[$];

    initial begin
        stim_row_t     row;
        swarm_result_t fx;

        sw_count   = 20;
        sw_inertia = 1638;
        sw_cogn    = 4096;
        sw_social  = 4096;
        sw_floor   = 24'sd0;
        sw_ceil    = 24'sd524288;
        sw_best_fit = FIT_MAX;
        sw_best_pos = '0;
        sw_best_idx = '0;

        // Directed rows. Hand-written values: out-of-range index right after
        // reset, an out-of-range load, and the round restart at maximum fitness.
        fx = '{6'd63, 24'sd0, 24'sd0, 24'sd0, FIT_MAX, 6'd0};
        directed.push_back('{FUNC_RESERVED, 63, 0, 0, 0, 0, 1, fx});
        directed.push_back('{FUNC_LOAD, 0, 24'h010000, 0, 0, 0, 0, fx});
        directed.push_back('{FUNC_LOAD, 1, 24'h7FFFFF, 0, 0, 0, 0, fx});
        directed.push_back('{FUNC_LOAD, 19, 24'h800000, 0, 0, 0, 0, fx});
        fx = '{6'd20, 24'sd0, 24'sd0, 24'sd0, FIT_MAX, 6'd0};
        directed.push_back('{FUNC_LOAD, 20, 24'h123456, 0, 0, 0, 1, fx});
        directed.push_back('{FUNC_REPORT, 1, 0, 32'h80000000, 0, 0, 0, fx});
        fx = '{6'd0, 24'sh010000, 24'sd0, 24'sh010000, FIT_MAX, 6'd0};
        directed.push_back('{FUNC_REPORT, 0, 0, 32'h7FFFFFFF, 0, 0, 1, fx});
        directed.push_back('{FUNC_REPORT, 19, 0, 32'h7FFFFFFF, 0, 0, 0, fx});
        directed.push_back('{FUNC_REPORT, 1, 0, 32'd5, 0, 0, 0, fx});
        directed.push_back('{FUNC_UPDATE, 0, 0, 0, 17'd65536, 17'd65536, 0, fx});
        directed.push_back('{FUNC_UPDATE, 1, 0, 0, 17'h1FFFF, 17'd0, 0, fx});
        directed.push_back('{FUNC_UPDATE, 19, 0, 0, 17'd0, 17'h1FFFF, 0, fx});
        directed.push_back('{FUNC_RESERVED, 1, 0, 0, 0, 0, 0, fx});
        directed.push_back('{FUNC_UPDATE, 20, 0, 0, 17'd1000, 17'd1000, 0, fx});
        directed.push_back('{FUNC_REPORT, 63, 0, 32'h80000000, 0, 0, 0, fx});

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[k]) begin
            row = directed[k];
            if (row.has_value) fixed_checks.push_back('{accepted_count, row.value});
            send_item(row.func, row.idx, row.start_pos, row.fitness, row.r_cogn, row.r_soc);
        end

        // Register extremes: full swarm with maximum gains and widest bounds,
        // then a single particle with zero gains and inverted bounds.
        configure(64, 65535, 65535, 65535, 24'h800000, 24'h7FFFFF);
        for (int i = 0; i < 64; i++) send_legal(FUNC_LOAD, i, 0);
        random_phase(120);
        configure(1, 0, 0, 0, 24'h100000, 24'hF00000);
        random_phase(40);

        // Random settings; the third phase also holds the receiver off for a
        // long stretch so the block backs up into its input.
        for (int p = 0; p < 4; p++) begin
            configure(($urandom_range(0, 2) == 0) ? 64 : $urandom_range(1, 64),
                      $urandom_range(0, 8191), $urandom_range(0, 16383),
                      $urandom_range(0, 16383), -$urandom_range(0, 1 << 20),
                      $urandom_range(0, 1 << 20));
            if (p == 2) hold_request = 1'b1;
            random_phase(100);
        end

        // Last phase at the reset settings with no idling on either side.
        configure(20, 1638, 4096, 4096, 0, 524288);
        quiet = 1'b1;
        random_phase(100);

        drain();
        $display("Covered %0d transactions (%0d particle updates) over %0d register settings.",
                 accepted_count, update_count, config_phases + 1);
        $display("Results checked: %0d, mismatches: %0d.", result_count, error_count);
        if (error_count == 0 && fixed_checks.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

/* particle_swarm_update_top.f */
hdl/psu_pkg.sv
hdl/psu_ram.sv
hdl/particle_swarm_update_top.sv
tb/particle_swarm_update_top_tb.sv
